/* hdl/gbt_pkg.sv */
// Shared types and constants of the graph traversal unit.
package gbt_pkg;

  // Width of a vertex id on the channels.
  localparam int unsigned ID_W = 6;

  typedef enum logic [1:0] {
    CMD_ADD_VERTEX = 2'd0,
    CMD_ADD_EDGE   = 2'd1,
    CMD_TRAVERSE   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_VISIT      = 3'd0,
    ST_OK         = 3'd1,
    ST_SRC_MISS   = 3'd2,
    ST_DST_MISS   = 3'd3,
    ST_EDGES_FULL = 3'd4,
    ST_START_MISS = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_VADD,
    S_ECHK,
    S_ETAILRD,
    S_ETAIL,
    S_ELINK,
    S_TINIT,
    S_POP,
    S_CUR,
    S_HEAD,
    S_EDGE,
    S_NEXT,
    S_EMIT,
    S_RESP
  } state_t;

  // Conditions reported by the datapath to the sequencer.
  typedef struct packed {
    logic a_ok;
    logic b_ok;
    logic full;
    logic tail_nil;
    logic e_nil;
    logic cnt_zero;
    logic out_free;
  } stat_t;

  // Sequencer outputs.
  typedef struct packed {
    state_t state;
    logic   idle;
  } ctrl_t;

endpackage

/* hdl/gbt_if.sv */
// Channel interfaces for commands and results.
interface gbt_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [gbt_pkg::ID_W-1:0]  vertex_a;
  logic [gbt_pkg::ID_W-1:0]  vertex_b;
  logic                      order;

  modport source (output valid, cmd, vertex_a, vertex_b, order, input ready);
  modport sink (input valid, cmd, vertex_a, vertex_b, order, output ready);
endinterface

interface gbt_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [gbt_pkg::ID_W-1:0]  visited_vertex;
  logic                      last;

  modport source (output valid, status, visited_vertex, last, input ready);
  modport sink (input valid, status, visited_vertex, last, output ready);
endinterface

/* hdl/gbt_ctrl.sv */
// Sequencer of the graph traversal unit.
module gbt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [1:0]      cmd,
  input  gbt_pkg::stat_t  stat,
  output gbt_pkg::ctrl_t  ctrl
);

  gbt_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      gbt_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            gbt_pkg::CMD_ADD_VERTEX: state_next = gbt_pkg::S_VADD;
            gbt_pkg::CMD_ADD_EDGE:   state_next = gbt_pkg::S_ECHK;
            gbt_pkg::CMD_TRAVERSE:   state_next = gbt_pkg::S_TINIT;
            default:                 state_next = gbt_pkg::S_IDLE;
          endcase
        end
      end
      gbt_pkg::S_VADD: state_next = gbt_pkg::S_RESP;
      gbt_pkg::S_ECHK: begin
        state_next = (stat.a_ok && stat.b_ok && !stat.full) ? gbt_pkg::S_ETAILRD
                                                            : gbt_pkg::S_RESP;
      end
      gbt_pkg::S_ETAILRD: state_next = gbt_pkg::S_ETAIL;
      gbt_pkg::S_ETAIL: begin
        state_next = stat.tail_nil ? gbt_pkg::S_RESP : gbt_pkg::S_ELINK;
      end
      gbt_pkg::S_ELINK: state_next = gbt_pkg::S_RESP;
      gbt_pkg::S_TINIT: state_next = stat.a_ok ? gbt_pkg::S_POP : gbt_pkg::S_RESP;
      gbt_pkg::S_POP:   state_next = gbt_pkg::S_CUR;
      gbt_pkg::S_CUR:   state_next = gbt_pkg::S_HEAD;
      gbt_pkg::S_HEAD:  state_next = gbt_pkg::S_EDGE;
      gbt_pkg::S_EDGE:  state_next = stat.e_nil ? gbt_pkg::S_EMIT : gbt_pkg::S_NEXT;
      gbt_pkg::S_NEXT:  state_next = gbt_pkg::S_EDGE;
      gbt_pkg::S_EMIT: begin
        if (stat.out_free) begin
          state_next = stat.cnt_zero ? gbt_pkg::S_IDLE : gbt_pkg::S_POP;
        end
      end
      gbt_pkg::S_RESP: begin
        if (stat.out_free) begin
          state_next = gbt_pkg::S_IDLE;
        end
      end
      default: state_next = gbt_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl.state = state;
    ctrl.idle  = (state == gbt_pkg::S_IDLE);
  end

endmodule

/* hdl/gbt_datapath.sv */
// Graph stores, work list and result register of the traversal unit.
module gbt_datapath #(
  parameter int unsigned VERTICES = 64,
  parameter int unsigned EDGES    = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [gbt_pkg::ID_W-1:0]  vertex_a,
  input  logic [gbt_pkg::ID_W-1:0]  vertex_b,
  input  logic                      order,
  input  gbt_pkg::ctrl_t            ctrl,
  output gbt_pkg::stat_t            stat,
  gbt_rsp_if.source                 rsp
);

  localparam int unsigned VW  = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int unsigned CW  = $clog2(VERTICES + 1);
  localparam int unsigned EAW = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int unsigned EW  = $clog2(EDGES + 1);
  localparam logic [EW-1:0] NIL = EW'(EDGES);

  gbt_pkg::state_t state;

  logic [gbt_pkg::ID_W-1:0] a_id, b_id;
  logic                     depth;
  logic [VERTICES-1:0]      present;
  logic [VERTICES-1:0]      visited;
  logic [EW-1:0]            edges_used;
  logic [EW-1:0]            e;
  logic [CW-1:0]            rd, cnt;
  logic [VW-1:0]            cur;
  gbt_pkg::status_t         resp;

  logic [EW-1:0] head_mem [VERTICES];
  logic [EW-1:0] tail_mem [VERTICES];
  logic [VW-1:0] tgt_mem  [EDGES];
  logic [EW-1:0] link_mem [EDGES];
  logic [VW-1:0] wl_mem   [VERTICES];

  logic [EW-1:0] head_rdata, tail_rdata, link_rdata;
  logic [VW-1:0] tgt_rdata, wl_rdata;

  logic          a_in_range, b_in_range, a_ok, b_ok, addable, t_new, out_load;
  logic [VW-1:0] a_idx, b_idx;
  logic [CW-1:0] slot, pop_addr;

  assign state = ctrl.state;

  // Vertex checks and work list addressing.
  always_comb begin
    a_idx      = VW'(a_id);
    b_idx      = VW'(b_id);
    a_in_range = (32'(a_id) < VERTICES);
    b_in_range = (32'(b_id) < VERTICES);
    a_ok       = a_in_range && present[a_idx];
    b_ok       = b_in_range && present[b_idx];
    addable    = a_in_range && !present[a_idx];
    t_new      = !visited[tgt_rdata];
    slot       = depth ? cnt : (rd + cnt);
    pop_addr   = depth ? (cnt - CW'(1)) : rd;
    out_load   = stat.out_free && (state == gbt_pkg::S_RESP || state == gbt_pkg::S_EMIT);
  end

  // Status toward the sequencer.
  always_comb begin
    stat.a_ok     = a_ok;
    stat.b_ok     = b_ok;
    stat.full     = (edges_used == NIL);
    stat.tail_nil = (tail_rdata == NIL);
    stat.e_nil    = (e == NIL);
    stat.cnt_zero = (cnt == '0);
    stat.out_free = !rsp.valid || rsp.ready;
  end

  // Command fields of the current transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_id  <= vertex_a;
      b_id  <= vertex_b;
      depth <= order;
    end
  end

  // Control registers: presence, edge count, work list pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      present    <= '0;
      edges_used <= '0;
      rd         <= '0;
      cnt        <= '0;
    end else begin
      unique case (state)
        gbt_pkg::S_VADD: begin
          if (addable) begin
            present[a_idx] <= 1'b1;
          end
        end
        gbt_pkg::S_ETAIL: edges_used <= edges_used + EW'(1);
        gbt_pkg::S_TINIT: begin
          if (a_ok) begin
            rd  <= '0;
            cnt <= CW'(1);
          end
        end
        gbt_pkg::S_POP: begin
          cnt <= cnt - CW'(1);
          if (!depth) begin
            rd <= rd + CW'(1);
          end
        end
        gbt_pkg::S_NEXT: begin
          if (t_new) begin
            cnt <= cnt + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the sequence.
  always_ff @(posedge clk) begin
    unique case (state)
      gbt_pkg::S_VADD: resp <= a_in_range ? gbt_pkg::ST_OK : gbt_pkg::ST_SRC_MISS;
      gbt_pkg::S_ECHK: begin
        priority if (!a_ok)         resp <= gbt_pkg::ST_SRC_MISS;
        else if (!b_ok)             resp <= gbt_pkg::ST_DST_MISS;
        else if (edges_used == NIL) resp <= gbt_pkg::ST_EDGES_FULL;
        else                        resp <= gbt_pkg::ST_OK;
      end
      gbt_pkg::S_ETAIL: e <= tail_rdata;
      gbt_pkg::S_TINIT: begin
        resp <= gbt_pkg::ST_START_MISS;
        if (a_ok) begin
          // Only the start vertex is marked at the start of a walk.
          visited <= VERTICES'(1) << a_idx;
        end
      end
      gbt_pkg::S_CUR:  cur <= wl_rdata;
      gbt_pkg::S_HEAD: e <= head_rdata;
      gbt_pkg::S_NEXT: begin
        if (t_new) begin
          visited[tgt_rdata] <= 1'b1;
        end
        e <= link_rdata;
      end
      default: ;
    endcase
  end

  // List head store.
  always_ff @(posedge clk) begin
    if (state == gbt_pkg::S_VADD && addable) begin
      head_mem[a_idx] <= NIL;
    end else if (state == gbt_pkg::S_ETAIL && tail_rdata == NIL) begin
      head_mem[a_idx] <= edges_used;
    end
    head_rdata <= head_mem[wl_rdata];
  end

  // List tail store.
  always_ff @(posedge clk) begin
    if (state == gbt_pkg::S_VADD && addable) begin
      tail_mem[a_idx] <= NIL;
    end else if (state == gbt_pkg::S_ETAIL) begin
      tail_mem[a_idx] <= edges_used;
    end
    tail_rdata <= tail_mem[a_idx];
  end

  // Edge target store.
  always_ff @(posedge clk) begin
    if (state == gbt_pkg::S_ETAIL) begin
      tgt_mem[edges_used[EAW-1:0]] <= b_idx;
    end
    tgt_rdata <= tgt_mem[e[EAW-1:0]];
  end

  // Edge link store.
  always_ff @(posedge clk) begin
    if (state == gbt_pkg::S_ETAIL) begin
      link_mem[edges_used[EAW-1:0]] <= NIL;
    end else if (state == gbt_pkg::S_ELINK) begin
      link_mem[e[EAW-1:0]] <= edges_used - EW'(1);
    end
    link_rdata <= link_mem[e[EAW-1:0]];
  end

  // Work list: queue or stack of pending vertices.
  always_ff @(posedge clk) begin
    if (state == gbt_pkg::S_TINIT && a_ok) begin
      wl_mem[0] <= a_idx;
    end else if (state == gbt_pkg::S_NEXT && t_new) begin
      wl_mem[slot[VW-1:0]] <= tgt_rdata;
    end
    wl_rdata <= wl_mem[pop_addr[VW-1:0]];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == gbt_pkg::S_EMIT) begin
        rsp.status         <= gbt_pkg::ST_VISIT;
        rsp.visited_vertex <= gbt_pkg::ID_W'(cur);
        rsp.last           <= (cnt == '0);
      end else begin
        rsp.status         <= resp;
        rsp.visited_vertex <= '0;
        rsp.last           <= 1'b1;
      end
    end
  end

  // The work list never holds more vertices than exist.
  assert property (@(posedge clk) disable iff (rst) 32'(cnt) <= VERTICES)
    else $error("work list count exceeds vertex count");

  // A pop is only started with a pending vertex.
  assert property (@(posedge clk) disable iff (rst) state == gbt_pkg::S_POP |-> cnt != '0)
    else $error("pop from empty work list");

  // Every stored edge points at a present vertex.
  assert property (@(posedge clk) disable iff (rst)
    state == gbt_pkg::S_NEXT |-> present[tgt_rdata])
    else $error("edge target not present");

  // The edge store count stays within its capacity.
  assert property (@(posedge clk) disable iff (rst) 32'(edges_used) <= EDGES)
    else $error("edge count exceeds capacity");

endmodule

/* hdl/graph_bfs_dfs_traversal_unit.sv */
// Top level of the graph build and breadth/depth traversal unit.
//
//   Channel  Role    Transaction carries
//   req      sink    cmd, vertex_a, vertex_b, order
//   rsp      source  status, visited_vertex, last
//
// Add vertex: add step, then result step. Add edge: check, tail read, tail and,
// if the list was not empty, link, then result. Traversal: init, then per vertex
// pop, read, head, edge walk and emit; single-ported memories, one access a step.
// Reset clears presence, the edge count, the work list pointers, the result valid
// flag and the sequencer; no clearing pass. The command channel is ready only
// while the sequencer is idle; a stalled result channel holds the sequencer in its result or emit step.
module graph_bfs_dfs_traversal_unit #(
  parameter int unsigned VERTICES = 64,
  parameter int unsigned EDGES    = 256
) (
  input  logic      clk,
  input  logic      rst,
  gbt_req_if.sink   req,
  gbt_rsp_if.source rsp
);

  gbt_pkg::ctrl_t ctrl;
  gbt_pkg::stat_t stat;
  logic           accept;

  // Commands are taken only between sequences.
  assign req.ready = ctrl.idle;
  assign accept    = req.valid && ctrl.idle;

  gbt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (req.cmd),
    .stat   (stat),
    .ctrl   (ctrl)
  );

  gbt_datapath #(
    .VERTICES (VERTICES),
    .EDGES    (EDGES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .vertex_a (req.vertex_a),
    .vertex_b (req.vertex_b),
    .order    (req.order),
    .ctrl     (ctrl),
    .stat     (stat),
    .rsp      (rsp)
  );

endmodule

/* sim/graph_bfs_dfs_traversal_unit_tb.sv */
// Testbench for the graph build and breadth/depth traversal unit.
`timescale 1ns / 100ps

module graph_bfs_dfs_traversal_unit_tb;

  localparam int NV = 64;
  localparam int NE = 256;
  localparam int DRAIN_CYCLES = 50;
  localparam int WATCHDOG_LIMIT = 50000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] a;
    logic [5:0] b;
    logic       ord;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] vertex;
    logic       last;
  } rsp_item_t;

  // One row of the directed table; has_exp marks a typed-in expectation.
  typedef struct {
    cmd_item_t         item;
    logic              has_exp;
    gbt_pkg::status_t  exp_status;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gbt_req_if req ();
  gbt_rsp_if rsp ();

  graph_bfs_dfs_traversal_unit u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the graph.
  logic       present_q [NV];
  int         head_q [NV];
  int         tail_q [NV];
  logic [5:0] target_q [NE];
  int         link_q [NE];
  int         edge_count;

  rsp_item_t  pending_rsp[$];
  int         errors = 0;
  int         n_cmds = 0;
  int         n_rsps = 0;
  int         n_visits = 0;
  int         idle_cycles = 0;
  int         rsp_stall_pct = 20;

  // Append the results one command produces to the pending queue.
  function automatic void graph_predict(cmd_item_t it);
    rsp_item_t   r;
    logic        mark [NV];
    logic [5:0]  wl [NV];
    int          rd, cnt, n, e, g, slot;
    logic [5:0]  cur;
    int          first;
    first = pending_rsp.size();
    r = '0;
    case (it.cmd)
      gbt_pkg::CMD_ADD_VERTEX: begin
        if (!present_q[it.a]) begin
          present_q[it.a] = 1'b1;
          head_q[it.a] = NE;
          tail_q[it.a] = NE;
        end
        r.status = gbt_pkg::ST_OK;
        pending_rsp.push_back(r);
      end
      gbt_pkg::CMD_ADD_EDGE: begin
        if (!present_q[it.a]) r.status = gbt_pkg::ST_SRC_MISS;
        else if (!present_q[it.b]) r.status = gbt_pkg::ST_DST_MISS;
        else if (edge_count >= NE) r.status = gbt_pkg::ST_EDGES_FULL;
        else begin
          target_q[edge_count] = it.b;
          link_q[edge_count] = NE;
          if (tail_q[it.a] < NE) link_q[tail_q[it.a]] = edge_count;
          else head_q[it.a] = edge_count;
          tail_q[it.a] = edge_count;
          edge_count++;
          r.status = gbt_pkg::ST_OK;
        end
        pending_rsp.push_back(r);
      end
      gbt_pkg::CMD_TRAVERSE: begin
        if (!present_q[it.a]) begin
          r.status = gbt_pkg::ST_START_MISS;
          pending_rsp.push_back(r);
        end else begin
          foreach (mark[i]) mark[i] = 1'b0;
          wl[0] = it.a;
          cnt = 1;
          rd = 0;
          n = 0;
          mark[it.a] = 1'b1;
          while (cnt > 0 && n < NV) begin
            if (it.ord) begin
              cnt--;
              cur = wl[cnt];
            end else begin
              cur = wl[rd];
              rd++;
              cnt--;
            end
            r.status = gbt_pkg::ST_VISIT;
            r.vertex = cur;
            pending_rsp.push_back(r);
            n++;
            e = head_q[cur];
            g = 0;
            while (e < NE && g < NE) begin
              if (!mark[target_q[e]]) begin
                slot = it.ord ? cnt : rd + cnt;
                if (slot < NV) begin
                  wl[slot] = target_q[e];
                  cnt++;
                  mark[target_q[e]] = 1'b1;
                end
              end
              e = link_q[e];
              g++;
            end
          end
        end
      end
      default: ;
    endcase
    if (pending_rsp.size() > first) pending_rsp[pending_rsp.size() - 1].last = 1'b1;
  endfunction

  // Drive one command and wait for its transaction; then predict it.
  task automatic send_cmd(cmd_item_t it, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= it.cmd;
    req.vertex_a <= it.a;
    req.vertex_b <= it.b;
    req.order <= it.ord;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    graph_predict(it);
    n_cmds++;
    @(negedge clk);
  endtask

  // Hold the command channel quiet until every expected result has come.
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(negedge clk);
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  function automatic cmd_item_t mk(int c, int a, int b, int o);
    cmd_item_t it;
    it.cmd = 2'(c);
    it.a = 6'(a);
    it.b = 6'(b);
    it.ord = 1'(o);
    return it;
  endfunction

  // Pick a vertex that is present in the shadow graph.
  function automatic int pick_present();
    int v;
    v = $urandom_range(63);
    while (!present_q[v]) v = $urandom_range(63);
    return v;
  endfunction

  // Result checking and random back-pressure.
  always @(posedge clk) begin
    rsp_item_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      n_rsps++;
      if (pending_rsp.size() == 0) begin
        $error("unexpected result status=%0d vertex=%0d", rsp.status, rsp.visited_vertex);
        errors++;
      end else begin
        exp_r = pending_rsp.pop_front();
        if (exp_r.status == gbt_pkg::ST_VISIT) n_visits++;
        if (rsp.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, rsp.status);
          errors++;
        end
        if (rsp.visited_vertex !== exp_r.vertex) begin
          $error("visited_vertex: expected %0d, actual %0d", exp_r.vertex,
                 rsp.visited_vertex);
          errors++;
        end
        if (rsp.last !== exp_r.last) begin
          $error("last: expected %0d, actual %0d", exp_r.last, rsp.last);
          errors++;
        end
      end
    end
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("graph_bfs_dfs_traversal_unit_tb failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // Directed table, then random graphs.
  initial begin
    dir_row_t  rows[$];
    dir_row_t  row;
    cmd_item_t it;
    int        nv, k, pct;
    req.valid = 1'b0;
    req.cmd = '0;
    req.vertex_a = '0;
    req.vertex_b = '0;
    req.order = 1'b0;
    rsp.ready = 1'b0;
    foreach (present_q[i]) begin
      present_q[i] = 1'b0;
      head_q[i] = NE;
      tail_q[i] = NE;
    end
    foreach (link_q[i]) begin
      link_q[i] = NE;
      target_q[i] = '0;
    end
    edge_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Missing ends, missing start, ignored code, duplicates, both orders.
    row.has_exp = 1'b1;
    row.item = mk(gbt_pkg::CMD_TRAVERSE, 0, 0, 0);
    row.exp_status = gbt_pkg::ST_START_MISS; rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_ADD_EDGE, 63, 0, 0);
    row.exp_status = gbt_pkg::ST_SRC_MISS; rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_ADD_VERTEX, 0, 0, 0);
    row.exp_status = gbt_pkg::ST_OK; rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_ADD_VERTEX, 63, 63, 1);
    row.exp_status = gbt_pkg::ST_OK; rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_ADD_EDGE, 0, 5, 0);
    row.exp_status = gbt_pkg::ST_DST_MISS; rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_ADD_VERTEX, 5, 0, 0);
    row.exp_status = gbt_pkg::ST_OK; rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_ADD_EDGE, 0, 63, 0);
    row.exp_status = gbt_pkg::ST_OK; rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_ADD_EDGE, 0, 5, 1);
    row.exp_status = gbt_pkg::ST_OK; rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_ADD_EDGE, 63, 5, 0);
    row.exp_status = gbt_pkg::ST_OK; rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_ADD_EDGE, 5, 0, 0);
    row.exp_status = gbt_pkg::ST_OK; rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_ADD_EDGE, 0, 5, 0);
    row.exp_status = gbt_pkg::ST_OK; rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_ADD_EDGE, 0, 0, 0);
    row.exp_status = gbt_pkg::ST_OK; rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_ADD_VERTEX, 0, 0, 0);
    row.exp_status = gbt_pkg::ST_OK; rows.push_back(row);
    row.has_exp = 1'b0;
    row.item = mk(3, 42, 21, 1); rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_TRAVERSE, 0, 0, 0); rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_TRAVERSE, 0, 0, 1); rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_TRAVERSE, 63, 21, 1); rows.push_back(row);
    row.item = mk(gbt_pkg::CMD_TRAVERSE, 5, 42, 0); rows.push_back(row);
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        wait_drained();
        send_cmd(rows[i].item, 0);
        if (pending_rsp.size() != 1) begin
          $error("results: expected 1, actual %0d for row %0d", pending_rsp.size(), i);
          errors++;
        end else if (pending_rsp[0].status != rows[i].exp_status) begin
          $error("status: expected %0d, actual %0d for row %0d",
                 rows[i].exp_status, pending_rsp[0].status, i);
          errors++;
        end
      end else begin
        send_cmd(rows[i].item, 20);
      end
    end
    wait_drained();

    // Random part: add vertices, add edges mostly between present vertices, traverse.
    for (k = 0; k < 140; k++) begin
      pct = (k >= 60 && k < 100) ? 0 : 20;
      rsp_stall_pct = pct;
      if (k == 110) wait_drained();
      case ($urandom_range(9))
        0: it = mk(gbt_pkg::CMD_ADD_VERTEX, $urandom_range(63), $urandom_range(63),
                   $urandom_range(1));
        1, 2, 3, 4, 5, 6, 7: begin
          if ($urandom_range(9) == 0) begin
            it = mk(gbt_pkg::CMD_ADD_EDGE, $urandom_range(63), $urandom_range(63),
                    $urandom_range(1));
          end else begin
            it = mk(gbt_pkg::CMD_ADD_EDGE, pick_present(), pick_present(),
                    $urandom_range(1));
          end
        end
        8: it = mk(gbt_pkg::CMD_TRAVERSE,
                   $urandom_range(1) ? pick_present() : $urandom_range(63),
                   $urandom_range(63), $urandom_range(1));
        default: it = mk($urandom_range(3), $urandom_range(63), $urandom_range(63),
                         $urandom_range(1));
      endcase
      send_cmd(it, pct);
    end
    // Fill the edge store to the end and probe the full case.
    nv = 0;
    while (edge_count < NE) begin
      send_cmd(mk(gbt_pkg::CMD_ADD_EDGE, 0, $urandom_range(1) ? 63 : 5, 0), 20);
      nv++;
    end
    send_cmd(mk(gbt_pkg::CMD_ADD_EDGE, 5, 0, 1), 20);
    send_cmd(mk(gbt_pkg::CMD_TRAVERSE, 0, 0, 1), 20);
    send_cmd(mk(gbt_pkg::CMD_TRAVERSE, 63, 0, 0), 20);
    rsp_stall_pct = 20;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d commands, %0d results (%0d visits), %0d edges stored.",
             n_cmds, n_rsps, n_visits, edge_count);
    $display("Edge store filled with %0d extra edges; both orders and all errors hit.", nv);
    if (errors == 0) begin
      $display("graph_bfs_dfs_traversal_unit_tb passed");
    end else begin
      $display("graph_bfs_dfs_traversal_unit_tb failed");
    end
    $finish;
  end

endmodule
